[sv/rlf_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the resonant ladder filter lanes.
// No dependencies; every other file imports this package.
package rlf_pkg;

  localparam int DEF_LANES       = 4;
  localparam int DEF_SAMPLE_BITS = 24;

  localparam int STAGES     = 4;
  localparam int STAGE_BITS = 2;
  localparam int STEP_BITS  = 4;
  localparam int MAX_STEP   = 2 * STAGES + 1;

  localparam int ADDR_BITS = 4;
  localparam int DATA_BITS = 32;

  localparam int GAIN_BITS = 16;
  localparam int INV_BITS  = 17;
  localparam int RESO_BITS = 19;
  localparam int POLE_BITS = 2;
  localparam int COEF_BITS = 19;

  // Headroom above the sample width for the unsaturated intermediates.
  localparam int GUARD_BITS = 12;
  localparam int FRAC_BITS  = 16;

  localparam logic [GAIN_BITS-1:0] GAIN_RESET = '0;
  localparam logic [INV_BITS-1:0]  INV_RESET  = 17'h10000;
  localparam logic [RESO_BITS-1:0] RESO_RESET = '0;
  localparam logic [POLE_BITS-1:0] POLE_RESET = 2'd3;

  typedef enum logic [1:0] {
    REG_GAIN  = 2'd0,
    REG_INV   = 2'd1,
    REG_RESO  = 2'd2,
    REG_POLES = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_FB   = 3'd1,
    OP_U    = 3'd2,
    OP_U1   = 3'd3,
    OP_V    = 3'd4,
    OP_O    = 3'd5
  } op_t;

  typedef struct packed {
    logic [GAIN_BITS-1:0] gain;
    logic [INV_BITS-1:0]  inv;
    logic [RESO_BITS-1:0] reso;
    logic [POLE_BITS-1:0] pole_code;
  } coef_t;

  typedef struct packed {
    logic                  load;
    logic                  en;
    op_t                   op;
    logic [STAGE_BITS-1:0] stage;
    logic                  fin;
  } lane_ctl_t;

endpackage

[sv/rlf_ifs.sv]
`timescale 1ns / 1ps
// Stream interfaces for the lane samples and the filtered results.
// Depends on rlf_pkg for default widths.
interface rlf_sample_if import rlf_pkg::*; #(
  parameter int LANES       = DEF_LANES,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) ();
  logic                         valid;
  logic                         ready;
  logic [LANES*SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface rlf_filtered_if import rlf_pkg::*; #(
  parameter int LANES       = DEF_LANES,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) ();
  logic                         valid;
  logic                         ready;
  logic [LANES*SAMPLE_BITS-1:0] filtered;

  modport source (output valid, output filtered, input ready);
  modport sink   (input valid, input filtered, output ready);
endinterface

[sv/rlf_regs.sv]
`timescale 1ns / 1ps
// APB register file holding the shared filter coefficients.
// Depends on rlf_pkg.
module rlf_regs import rlf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready,
  output coef_t                coef
);

  reg_idx_t idx;
  logic     wr;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[ADDR_BITS-1:2]);
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef.gain      <= GAIN_RESET;
      coef.inv       <= INV_RESET;
      coef.reso      <= RESO_RESET;
      coef.pole_code <= POLE_RESET;
    end else if (wr) begin
      case (idx)
        REG_GAIN:  coef.gain      <= pwdata[GAIN_BITS-1:0];
        REG_INV:   coef.inv       <= pwdata[INV_BITS-1:0];
        REG_RESO:  coef.reso      <= pwdata[RESO_BITS-1:0];
        REG_POLES: coef.pole_code <= pwdata[POLE_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_GAIN:  prdata = DATA_BITS'(coef.gain);
      REG_INV:   prdata = DATA_BITS'(coef.inv);
      REG_RESO:  prdata = DATA_BITS'(coef.reso);
      REG_POLES: prdata = DATA_BITS'(coef.pole_code);
      default:   prdata = '0;
    endcase
  end

endmodule

[sv/rlf_lane.sv]
`timescale 1ns / 1ps
// One ladder lane: four stage states, previous output, one shared multiplier.
// Depends on rlf_pkg; sequenced by rlf_seq.
module rlf_lane import rlf_pkg::*; #(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  lane_ctl_t                     ctl,
  input  coef_t                         coef,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  output logic signed [SAMPLE_BITS-1:0] last
);

  localparam int W  = SAMPLE_BITS + GUARD_BITS;
  localparam int PW = W + COEF_BITS + 1;
  localparam int HB = W - SAMPLE_BITS + 1;

  logic signed [SAMPLE_BITS-1:0] stage_store [STAGES];
  logic signed [SAMPLE_BITS-1:0] x;
  logic signed [SAMPLE_BITS-1:0] y;
  logic signed [W-1:0]           p;
  logic signed [W-1:0]           xw, lastw, sw, a, q, sum;
  logic        [COEF_BITS-1:0]   cf;
  logic signed [PW-1:0]          prod, rnd;
  logic        [HB-1:0]          hi;

  always_comb begin
    xw    = W'(x);
    lastw = W'(last);
    sw    = W'(stage_store[ctl.stage]);
    case (ctl.op)
      OP_FB: begin
        a  = lastw;
        cf = COEF_BITS'(coef.reso);
      end
      OP_U: begin
        a  = xw - p;
        cf = COEF_BITS'(coef.inv);
      end
      OP_U1: begin
        a  = xw - lastw;
        cf = COEF_BITS'(coef.inv);
      end
      OP_V: begin
        a  = p - sw;
        cf = COEF_BITS'(coef.inv);
      end
      OP_O: begin
        a  = p;
        cf = COEF_BITS'(coef.gain);
      end
      default: begin
        a  = '0;
        cf = '0;
      end
    endcase
    prod = PW'(a) * PW'($signed({1'b0, cf}));
    // round half up, then floor shift
    rnd  = prod + PW'(1 << (FRAC_BITS - 1));
    q    = rnd[W+FRAC_BITS-1:FRAC_BITS];
    sum  = q + sw;
    hi   = sum[W-1:SAMPLE_BITS-1];
    if (hi == '0 || hi == '1) begin
      y = sum[SAMPLE_BITS-1:0];
    end else if (sum[W-1]) begin
      y = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      y = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < STAGES; i++) begin
        stage_store[i] <= '0;
      end
      last <= '0;
    end else if (ctl.en && ctl.op == OP_O) begin
      stage_store[ctl.stage] <= y;
      if (ctl.fin) begin
        last <= y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      x <= sample;
    end
    if (ctl.en) begin
      p <= (ctl.op == OP_O) ? W'(y) : q;
    end
  end

endmodule

[sv/rlf_seq.sv]
`timescale 1ns / 1ps
// Step sequencer shared by all lanes: accept, multiply steps, result hold.
// Depends on rlf_pkg.
module rlf_seq import rlf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 out_free,
  input  logic [POLE_BITS-1:0] pole_code,
  output logic                 in_ready,
  output logic                 out_load,
  output lane_ctl_t            ctl
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_HOLD = 3'b100
  } state_t;

  state_t               state, state_next;
  logic [STEP_BITS-1:0] step, step_next;
  logic [STEP_BITS-1:0] last_step;
  logic [STEP_BITS-1:0] step_m2;
  logic                 in_fire;
  logic                 fin;

  assign in_ready  = (state == S_IDLE) || (state == S_HOLD && out_free);
  assign out_load  = (state == S_HOLD) && out_free;
  assign in_fire   = in_valid && in_ready;
  assign last_step = (pole_code == '0) ? STEP_BITS'(1)
                   : STEP_BITS'({pole_code, 1'b1}) + STEP_BITS'(2);
  assign fin       = (state == S_RUN) && (step >= last_step);
  assign step_m2   = step - STEP_BITS'(2);

  always_comb begin
    ctl.load  = in_fire;
    ctl.en    = (state == S_RUN);
    ctl.fin   = fin;
    ctl.op    = OP_NONE;
    ctl.stage = '0;
    if (state == S_RUN) begin
      if (pole_code == '0) begin
        ctl.op = (step == '0) ? OP_U1 : OP_O;
      end else if (step == '0) begin
        ctl.op = OP_FB;
      end else if (step == STEP_BITS'(1)) begin
        ctl.op = OP_U;
      end else begin
        ctl.op    = step[0] ? OP_O : OP_V;
        ctl.stage = step_m2[STAGE_BITS:1];
      end
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          state_next = S_RUN;
          step_next  = '0;
        end
      end
      S_RUN: begin
        if (fin) begin
          state_next = S_HOLD;
        end else begin
          step_next = step + STEP_BITS'(1);
        end
      end
      S_HOLD: begin
        if (in_fire) begin
          state_next = S_RUN;
          step_next  = '0;
        end else if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_RUN |-> step <= STEP_BITS'(MAX_STEP))
    else $error("step counter past last step");

  a_fire_starts: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> state == S_RUN && step == '0)
    else $error("accepted transfer did not start a run");

  a_fin_holds: assert property (@(posedge clk) disable iff (rst)
    fin |=> state == S_HOLD)
    else $error("finished run did not move to hold");

endmodule

[sv/rlf_merge.sv]
`timescale 1ns / 1ps
// Output stage: gathers every lane's result into one registered transfer.
// Depends on rlf_pkg and rlf_filtered_if.
module rlf_merge import rlf_pkg::*; #(
  parameter int LANES       = DEF_LANES,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         load,
  input  logic [LANES*SAMPLE_BITS-1:0] lanes_last,
  output logic                         out_free,
  rlf_filtered_if.source               dout
);

  assign out_free = !dout.valid || dout.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (load) begin
      dout.valid <= 1'b1;
    end else if (dout.ready) begin
      dout.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dout.filtered <= lanes_last;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> (!dout.valid || dout.ready))
    else $error("pending result overwritten");

endmodule

[sv/resonant_ladder_filter_lanes.sv]
`timescale 1ns / 1ps
// Resonant ladder low-pass filter, one to four poles, LANES voices in parallel.
// Depends on rlf_pkg, rlf_ifs, rlf_regs, rlf_seq, rlf_lane, rlf_merge.
//
// Usage:
//   din carries one sample per lane (lane i in bits [i*SAMPLE_BITS +: SAMPLE_BITS]),
//   dout carries one filtered sample per lane in the same layout. A transfer
//   happens on a clock edge with valid and ready high.
//   Coefficients are written over the APB port (byte address 4*index) while
//   no sample is in flight; all lanes share them.
//   Each lane has one multiplier that runs one product per cycle while a
//   sample is in the lanes: feedback, input scaling, then two products per
//   active pole; with one pole there is no resonance feedback step, only
//   input scaling and the output product. The result is then registered on
//   dout. A new sample is taken as the result moves to the output register.
//   If dout is stalled, one result waits in the output register and the
//   next is held in the lanes; din stays not ready until the output frees.
//   Reset clears all stage states and previous outputs to zero and loads the
//   coefficient registers with their defaults (four poles, unity inverse).
module resonant_ladder_filter_lanes import rlf_pkg::*; #(
  parameter int LANES       = DEF_LANES,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  rlf_sample_if.sink           din,
  rlf_filtered_if.source       dout,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready
);

  coef_t                        coef;
  lane_ctl_t                    ctl;
  logic                         out_load;
  logic                         out_free;
  logic                         in_ready;
  logic [LANES*SAMPLE_BITS-1:0] lanes_last;

  assign din.ready = in_ready;

  rlf_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .coef    (coef)
  );

  rlf_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (din.valid),
    .out_free  (out_free),
    .pole_code (coef.pole_code),
    .in_ready  (in_ready),
    .out_load  (out_load),
    .ctl       (ctl)
  );

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    logic signed [SAMPLE_BITS-1:0] lane_last;

    rlf_lane #(
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane (
      .clk    (clk),
      .rst    (rst),
      .ctl    (ctl),
      .coef   (coef),
      .sample ($signed(din.sample[i*SAMPLE_BITS +: SAMPLE_BITS])),
      .last   (lane_last)
    );

    assign lanes_last[i*SAMPLE_BITS +: SAMPLE_BITS] = lane_last;
  end

  rlf_merge #(
    .LANES       (LANES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_merge (
    .clk        (clk),
    .rst        (rst),
    .load       (out_load),
    .lanes_last (lanes_last),
    .out_free   (out_free),
    .dout       (dout)
  );

endmodule

[bench/resonant_ladder_filter_lanes_test.sv]
`timescale 1ns / 1ps
// Self-checking bench for resonant_ladder_filter_lanes: random and directed lane samples,
// coefficient phases over APB, random stalls on both streams. Needs rlf_pkg, rlf_ifs and the RTL.
module resonant_ladder_filter_lanes_test;
  import rlf_pkg::*;

  localparam int LANES = DEF_LANES;
  localparam int SB    = DEF_SAMPLE_BITS;
  localparam int W     = LANES * SB;

  class filter_scoreboard;
    logic [GAIN_BITS-1:0] gain;
    logic [INV_BITS-1:0]  inv;
    logic [RESO_BITS-1:0] reso;
    logic [POLE_BITS-1:0] pole_code;
    longint stage_state[LANES][STAGES];
    longint prev_filtered[LANES];
    logic [W-1:0] pending_filtered[$];
    int errors;

    function new();
      gain      = GAIN_RESET;
      inv       = INV_RESET;
      reso      = RESO_RESET;
      pole_code = POLE_RESET;
      foreach (stage_state[i, j]) stage_state[i][j] = 0;
      foreach (prev_filtered[i]) prev_filtered[i] = 0;
      errors = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [DATA_BITS-1:0] word);
      case (idx)
        REG_GAIN:  gain      = word[GAIN_BITS-1:0];
        REG_INV:   inv       = word[INV_BITS-1:0];
        REG_RESO:  reso      = word[RESO_BITS-1:0];
        REG_POLES: pole_code = word[POLE_BITS-1:0];
        default: ;
      endcase
    endfunction

    function logic [DATA_BITS-1:0] reg_word(reg_idx_t idx);
      case (idx)
        REG_GAIN:  return DATA_BITS'(gain);
        REG_INV:   return DATA_BITS'(inv);
        REG_RESO:  return DATA_BITS'(reso);
        REG_POLES: return DATA_BITS'(pole_code);
        default:   return '0;
      endcase
    endfunction

    // Q.16 product rounded half up, floor division by 2^16
    function longint scale_q16(longint a, longint coef);
      return (a * coef + 64'sd32768) >>> 16;
    endfunction

    function longint clamp(longint v);
      longint hi;
      longint lo;
      hi = (64'sd1 <<< (SB - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
    endfunction

    function void take_samples(logic [W-1:0] samples);
      logic [W-1:0] filtered;
      longint x;
      longint last;
      longint y;
      longint v;
      for (int lane = 0; lane < LANES; lane++) begin
        x    = longint'($signed(samples[lane*SB +: SB]));
        last = prev_filtered[lane];
        if (pole_code == 0) begin
          v = scale_q16(x - last, longint'(inv));
          y = clamp(scale_q16(v, longint'(gain)) + stage_state[lane][0]);
          stage_state[lane][0] = y;
        end else begin
          y = scale_q16(x - scale_q16(last, longint'(reso)), longint'(inv));
          for (int k = 0; k <= int'(pole_code); k++) begin
            v = scale_q16(y - stage_state[lane][k], longint'(inv));
            y = clamp(scale_q16(v, longint'(gain)) + stage_state[lane][k]);
            stage_state[lane][k] = y;
          end
        end
        prev_filtered[lane] = y;
        filtered[lane*SB +: SB] = y[SB-1:0];
      end
      pending_filtered.push_back(filtered);
    endfunction

    function void check_lane(int lane, logic [W-1:0] want, logic [W-1:0] got);
      if (got[lane*SB +: SB] !== want[lane*SB +: SB]) begin
        $error("filtered_%0d: expected %0d, actual %0d", lane,
               $signed(want[lane*SB +: SB]), $signed(got[lane*SB +: SB]));
        errors++;
      end
    endfunction

    function void check_filtered(logic [W-1:0] got);
      logic [W-1:0] want;
      if (pending_filtered.size() == 0) begin
        $error("filtered transfer with no sample pending: %h", got);
        errors++;
        return;
      end
      want = pending_filtered.pop_front();
      check_lane(0, want, got);
      check_lane(1, want, got);
      check_lane(2, want, got);
      check_lane(3, want, got);
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ADDR_BITS-1:0] paddr;
  logic [DATA_BITS-1:0] pwdata;
  logic [DATA_BITS-1:0] prdata;
  logic                 pready;

  rlf_sample_if   #(.LANES(LANES), .SAMPLE_BITS(SB)) din_if ();
  rlf_filtered_if #(.LANES(LANES), .SAMPLE_BITS(SB)) dout_if ();

  resonant_ladder_filter_lanes #(.LANES(LANES), .SAMPLE_BITS(SB)) uut (
    .clk     (clk),
    .rst     (rst),
    .din     (din_if),
    .dout    (dout_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  filter_scoreboard sb = new();
  logic [W-1:0] last_sent = '0;
  bit in_gaps_on = 1'b1;
  bit out_stalls_on = 1'b1;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && dout_if.valid && dout_if.ready) sb.check_filtered(dout_if.filtered);
  end

  initial begin
    int stall;
    dout_if.ready = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = out_stalls_on ? $urandom_range(0, 8) : 0;
      if (stall > 0) begin
        dout_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      dout_if.ready <= 1'b1;
      do @(posedge clk); while (!dout_if.valid);
    end
  end

  task automatic write_coef(input reg_idx_t idx, input logic [DATA_BITS-1:0] word);
    logic [DATA_BITS-1:0] readback;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, word);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    readback = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback !== sb.reg_word(idx)) begin
      $error("prdata %s: expected %0d, actual %0d", idx.name(), sb.reg_word(idx), readback);
      sb.errors++;
    end
  endtask

  task automatic send_samples(input logic [W-1:0] samples);
    int gap;
    gap = in_gaps_on ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      din_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    din_if.valid  <= 1'b1;
    din_if.sample <= samples;
    do @(posedge clk); while (!din_if.ready);
    sb.take_samples(samples);
    last_sent = samples;
  endtask

  task automatic drain_filter();
    din_if.valid <= 1'b0;
    while (sb.pending_filtered.size() != 0) @(posedge clk);
  endtask

  function automatic logic [DATA_BITS-1:0] pick_word(int lo, int hi);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return DATA_BITS'(lo);
    if (r == 1) return DATA_BITS'(hi);
    if (r == 2) return $urandom;
    return DATA_BITS'($urandom_range(hi, lo));
  endfunction

  // smooth runs, held steps, extremes and noise per lane
  function automatic logic [W-1:0] next_samples();
    logic [W-1:0] word;
    logic [SB-1:0] prev;
    logic [SB-1:0] v;
    int kind;
    for (int lane = 0; lane < LANES; lane++) begin
      prev = last_sent[lane*SB +: SB];
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        v = prev + SB'($urandom_range(0, 8191)) - SB'(4096);
      end else if (kind < 60) begin
        v = SB'($urandom);
      end else if (kind < 75) begin
        case ($urandom_range(0, 4))
          0: v = {1'b0, {(SB-1){1'b1}}};
          1: v = {1'b1, {(SB-1){1'b0}}};
          2: v = '0;
          3: v = '1;
          default: v = SB'(1);
        endcase
      end else if (kind < 90) begin
        v = prev;
      end else begin
        v = SB'($urandom_range(0, 8191)) - SB'(4096);
      end
      word[lane*SB +: SB] = v;
    end
    return word;
  endfunction

  function automatic logic [W-1:0] all_lanes(logic [SB-1:0] v);
    return {LANES{v}};
  endfunction

  initial begin
    logic [SB-1:0] smax;
    logic [SB-1:0] smin;
    bit first;
    smax = {1'b0, {(SB-1){1'b1}}};
    smin = {1'b1, {(SB-1){1'b0}}};
    rst           = 1'b1;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    din_if.valid  = 1'b0;
    din_if.sample = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset coefficients
    send_samples(all_lanes(smax));
    send_samples(all_lanes(smin));
    send_samples({smax, smin, SB'(1), {SB{1'b1}}});
    drain_filter();

    // full gain, half inverse, full resonance, four poles
    write_coef(REG_GAIN, 32'd65535);
    write_coef(REG_INV, 32'd32768);
    write_coef(REG_RESO, 32'd262144);
    write_coef(REG_POLES, 32'd3);
    send_samples(all_lanes(smax));
    send_samples(all_lanes(smax));
    send_samples(all_lanes(smin));
    send_samples(all_lanes(smin));
    send_samples(all_lanes('0));
    send_samples({smin, smax, smin, smax});
    send_samples({4{SB'(24'h555555)}});
    send_samples({4{SB'(24'hAAAAAA)}});
    drain_filter();

    // pole count changes carry the state over
    write_coef(REG_POLES, 32'd0);
    send_samples(all_lanes(smax));
    send_samples(all_lanes(smin));
    send_samples(all_lanes(SB'(1)));
    send_samples(all_lanes('1));
    drain_filter();
    write_coef(REG_POLES, 32'd1);
    send_samples(all_lanes(smax));
    send_samples({smax, smin, {SB{1'b0}}, smax});
    drain_filter();
    write_coef(REG_POLES, 32'd2);
    send_samples(all_lanes(smin));
    send_samples({SB'(1), smax, smin, {SB{1'b1}}});
    drain_filter();

    first = 1'b1;
    repeat (14) begin
      in_gaps_on    = ($urandom_range(0, 3) != 0);
      out_stalls_on = ($urandom_range(0, 3) != 0);
      if (first) begin
        write_coef(REG_GAIN, 32'd0);
        write_coef(REG_INV, 32'd65536);
        write_coef(REG_RESO, 32'd0);
        write_coef(REG_POLES, 32'd3);
      end else begin
        if ($urandom_range(0, 4) != 0) write_coef(REG_GAIN, pick_word(0, 65535));
        if ($urandom_range(0, 4) != 0) write_coef(REG_INV, pick_word(32768, 65536));
        if ($urandom_range(0, 4) != 0) write_coef(REG_RESO, pick_word(0, 262144));
        if ($urandom_range(0, 4) != 0) write_coef(REG_POLES, pick_word(0, 3));
      end
      first = 1'b0;
      repeat (100) send_samples(next_samples());
      drain_filter();
    end

    repeat (20) @(posedge clk);
    if (sb.errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

[filelist.f]
sv/rlf_pkg.sv
sv/rlf_ifs.sv
sv/rlf_regs.sv
sv/rlf_lane.sv
sv/rlf_seq.sv
sv/rlf_merge.sv
sv/resonant_ladder_filter_lanes.sv
bench/resonant_ladder_filter_lanes_test.sv
